// ===== hw/rtl/sgm_pkg.sv =====
// ----------------------------------------------------------------------------
// sgm_pkg
// Shared widths, register indexes, state codes and types for the Sobel
// gradient magnitude block.
// ----------------------------------------------------------------------------
package sgm_pkg;

    localparam int MAX_COLS = 1024;
    localparam int MAX_ROWS = 1024;
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int DIM_W    = 11;
    localparam int MARGIN_W = 2;
    localparam int PIX_W    = 8;
    localparam int MAG_W    = 11;
    localparam int GRAD_W   = 12;
    localparam int ABS_W    = 10;
    // Largest Gx*Gx + Gy*Gy is 2 * 1020 * 1020, which fits in 21 bits.
    localparam int RAD_W    = 21;
    localparam int TDATA_W  = 32;
    // Each line-buffer entry holds the pixel two rows up and one row up.
    localparam int LB_W     = 2 * PIX_W;

    localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [1:0] REG_BORDER_MARGIN = 2'd2;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_READ = 6'b000010,
        ST_CALC = 6'b000100,
        ST_SQR  = 6'b001000,
        ST_ROOT = 6'b010000,
        ST_OUT  = 6'b100000
    } state_t;

    typedef struct packed {
        logic             done;
        logic [MAG_W-1:0] root;
    } isqrt_rsp_t;

endpackage

// ===== hw/rtl/sgm_ram.sv =====
// ----------------------------------------------------------------------------
// sgm_ram
// Generic simple dual-port RAM: one write port and one read port with
// registered read data.
// ----------------------------------------------------------------------------
module sgm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/sgm_isqrt.sv =====
// ----------------------------------------------------------------------------
// sgm_isqrt
// Bit-serial integer square root: one result bit per cycle, giving the
// floor of the square root of the radicand after RAD_W/2+1 steps.
// ----------------------------------------------------------------------------
module sgm_isqrt
    import sgm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [RAD_W-1:0] radicand,
    output isqrt_rsp_t       rsp
);

    logic [RAD_W-1:0] v_reg,   v_next;
    logic [RAD_W-1:0] res_reg, res_next;
    logic [RAD_W-1:0] bit_reg, bit_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [RAD_W-1:0] trial;

    assign trial = res_reg + bit_reg;

    always_comb
    begin
        v_next    = v_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            v_next    = radicand;
            res_next  = '0;
            bit_next  = {1'b1, {(RAD_W-1){1'b0}}};
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (v_reg >= trial)
            begin
                v_next   = v_reg - trial;
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            // The step with the lowest bit is the last one.
            if (bit_reg[0])
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg   <= v_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign rsp.done = done_reg;
    assign rsp.root = res_reg[MAG_W-1:0];

endmodule

// ===== hw/rtl/sobel_gradient_magnitude.sv =====
// ----------------------------------------------------------------------------
// sobel_gradient_magnitude
// Streaming 3x3 Sobel gradient magnitude over 8-bit greyscale pixels.
// ----------------------------------------------------------------------------
// Pixels enter in raster order, one item at a time, and each gives one result
// for the position one row and one column behind it. The two previous rows
// live in a single 1024-entry line-buffer RAM that is read and written back
// once per pixel; the magnitude is the floor of sqrt(Gx^2 + Gy^2) from a
// bit-serial square root. An item passes through the accepting cycle, the
// line-buffer read, kernel sum, squaring, the 11 steps and the finish flag of
// the square root and the output load, which waits for a free output side;
// no new pixel is accepted until that load.
// A finished result waits in the output register while the next pixel is
// accepted. Results in the border band, and at the lag before the first
// valid position of a frame, carry a magnitude of zero. Line-buffer contents
// are not cleared at reset. Configuration is taken at any time on the cfg
// channel but should only change while the block is idle.
// ----------------------------------------------------------------------------
module sobel_gradient_magnitude
    import sgm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // s_tdata: pixel[7:0]
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [PIX_W-1:0]   s_tdata,
    // s_tuser: frame_start
    input  logic               s_tuser,
    // m_tdata: magnitude[10:0], out_row[20:11], out_col[30:21], zero[31]
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,
    // m_tuser: out_valid
    output logic               m_tuser,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [DIM_W-1:0]   cfg_data
);

    state_t state_reg, state_next;

    logic [DIM_W-1:0]    width_reg, height_reg;
    logic [MARGIN_W-1:0] margin_reg;
    logic [DIM_W-1:0]    w_eff, h_eff;
    logic [DIM_W-1:0]    m_eff;

    logic [ROW_W-1:0] row_reg;
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] r_cur;
    logic [COL_W-1:0] c_cur;
    logic [DIM_W-1:0] c_inc, r_inc;

    logic [ROW_W-1:0] r_item_reg;
    logic [COL_W-1:0] c_item_reg;
    logic [PIX_W-1:0] px_reg;

    logic [PIX_W-1:0] win_reg [9];
    logic [LB_W-1:0]  lb_rdata;
    logic             lb_we;

    logic [GRAD_W-1:0] gx, gy;
    logic [GRAD_W-1:0] gx_abs, gy_abs;
    logic [ABS_W-1:0]  ax_reg, ay_reg;
    logic              in_frame_reg, keep_reg;
    logic [ROW_W-1:0]  orow;
    logic [COL_W-1:0]  ocol;
    logic              keep;

    logic [RAD_W-1:0] radicand;
    isqrt_rsp_t       sq_rsp;
    logic [MAG_W-1:0] mag_reg;

    logic             m_tvalid_reg;
    logic [TDATA_W-1:0] m_tdata_reg;
    logic             m_tuser_reg;
    logic             accept;
    logic             out_load;

    // Effective sizes: dimensions saturate to 1..MAX, a zero margin acts as 1.
    always_comb
    begin
        if (width_reg == '0)
        begin
            w_eff = DIM_W'(1);
        end
        else if (width_reg > DIM_W'(MAX_COLS))
        begin
            w_eff = DIM_W'(MAX_COLS);
        end
        else
        begin
            w_eff = width_reg;
        end
        if (height_reg == '0)
        begin
            h_eff = DIM_W'(1);
        end
        else if (height_reg > DIM_W'(MAX_ROWS))
        begin
            h_eff = DIM_W'(MAX_ROWS);
        end
        else
        begin
            h_eff = height_reg;
        end
        m_eff = (margin_reg == '0) ? DIM_W'(1) : DIM_W'(margin_reg);
    end

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_W'(512);
            height_reg <= DIM_W'(512);
            margin_reg <= MARGIN_W'(3);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:   width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT:  height_reg <= cfg_data;
                REG_BORDER_MARGIN: margin_reg <= cfg_data[MARGIN_W-1:0];
                default:           ;
            endcase
        end
    end

    // Position of the incoming pixel.
    always_comb
    begin
        if (s_tuser || ({1'b0, row_reg} >= h_eff))
        begin
            r_cur = s_tuser ? '0 : '0;
        end
        else
        begin
            r_cur = row_reg;
        end
        if (s_tuser || ({1'b0, col_reg} >= w_eff))
        begin
            c_cur = '0;
        end
        else
        begin
            c_cur = col_reg;
        end
        c_inc = {1'b0, c_cur} + DIM_W'(1);
        r_inc = {1'b0, r_cur} + DIM_W'(1);
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (accept)
        begin
            if (c_inc >= w_eff)
            begin
                col_reg <= '0;
                row_reg <= (r_inc >= h_eff) ? '0 : r_inc[ROW_W-1:0];
            end
            else
            begin
                col_reg <= c_inc[COL_W-1:0];
                row_reg <= r_cur;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            r_item_reg <= r_cur;
            c_item_reg <= c_cur;
            px_reg     <= s_tdata;
        end
    end

    // Line buffer: upper row in the high byte, middle row in the low byte.
    // The read is issued with the accepted pixel and written back in the following
    // cycle; the next read cannot come before that write.
    assign lb_we = (state_reg == ST_READ);

    sgm_ram #(
        .WIDTH (LB_W),
        .DEPTH (MAX_COLS)
    ) u_line_buffer (
        .clk   (clk),
        .we    (lb_we),
        .waddr (c_item_reg),
        .wdata ({lb_rdata[PIX_W-1:0], px_reg}),
        .raddr (c_cur),
        .rdata (lb_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (lb_we)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win_reg[i*3]   <= win_reg[i*3+1];
                win_reg[i*3+1] <= win_reg[i*3+2];
            end
            win_reg[2] <= lb_rdata[LB_W-1:PIX_W];
            win_reg[5] <= lb_rdata[PIX_W-1:0];
            win_reg[8] <= px_reg;
        end
    end

    // Kernel sums and the border test for the output position.
    always_comb
    begin
        gx = (GRAD_W'(win_reg[2]) + (GRAD_W'(win_reg[5]) << 1) + GRAD_W'(win_reg[8]))
           - (GRAD_W'(win_reg[0]) + (GRAD_W'(win_reg[3]) << 1) + GRAD_W'(win_reg[6]));
        gy = (GRAD_W'(win_reg[6]) + (GRAD_W'(win_reg[7]) << 1) + GRAD_W'(win_reg[8]))
           - (GRAD_W'(win_reg[0]) + (GRAD_W'(win_reg[1]) << 1) + GRAD_W'(win_reg[2]));
        gx_abs = gx[GRAD_W-1] ? (GRAD_W'(0) - gx) : gx;
        gy_abs = gy[GRAD_W-1] ? (GRAD_W'(0) - gy) : gy;
        orow = r_item_reg - ROW_W'(1);
        ocol = c_item_reg - COL_W'(1);
        keep = ({1'b0, orow} >= m_eff) && ({1'b0, ocol} >= m_eff)
            && (({1'b0, orow} + m_eff) <= (h_eff - DIM_W'(1)))
            && (({1'b0, ocol} + m_eff) <= (w_eff - DIM_W'(1)));
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CALC)
        begin
            ax_reg       <= gx_abs[ABS_W-1:0];
            ay_reg       <= gy_abs[ABS_W-1:0];
            in_frame_reg <= (r_item_reg != '0) && (c_item_reg != '0);
            keep_reg     <= keep;
        end
    end

    assign radicand = RAD_W'(ax_reg) * RAD_W'(ax_reg) + RAD_W'(ay_reg) * RAD_W'(ay_reg);

    sgm_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == ST_SQR),
        .radicand (radicand),
        .rsp      (sq_rsp)
    );

    always_ff @(posedge clk)
    begin
        if (sq_rsp.done)
        begin
            mag_reg <= sq_rsp.root;
        end
    end

    assign out_load = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (accept) state_next = ST_READ;
            ST_READ: state_next = ST_CALC;
            ST_CALC: state_next = ST_SQR;
            ST_SQR:  state_next = ST_ROOT;
            ST_ROOT: if (sq_rsp.done) state_next = ST_OUT;
            ST_OUT:  if (out_load) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_tuser_reg <= in_frame_reg;
            m_tdata_reg <= {1'b0,
                            in_frame_reg ? (c_item_reg - COL_W'(1)) : COL_W'(0),
                            in_frame_reg ? (r_item_reg - ROW_W'(1)) : ROW_W'(0),
                            (in_frame_reg && keep_reg) ? mag_reg : MAG_W'(0)};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef SYNTHESIS
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state register is not one-hot");

    a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_READ))
        else $error("accepted pixel did not start a line-buffer read");

    a_root_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        sq_rsp.done |-> (state_reg == ST_ROOT))
        else $error("square root finished outside its wait state");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> $stable(m_tdata))
        else $error("waiting result was overwritten");
`endif

endmodule
